### rtl/lbrm_pkg.sv
// ----------------------------------------------------------------------------
// lbrm_pkg
// Shared types, constants and neighbourhood offsets for the label boundary
// and ring marker.
// ----------------------------------------------------------------------------
package lbrm_pkg;

  localparam int MAX_SIDE      = 128;
  localparam int LABEL_BITS    = 8;
  localparam int COORD_BITS    = $clog2(MAX_SIDE);
  localparam int SIDE_BITS     = COORD_BITS + 1;
  localparam int NCOORD_BITS   = COORD_BITS + 2;
  localparam int ADDR_BITS     = 2 * COORD_BITS;
  localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int CFG_BITS      = 8;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int NUM_TAPS      = 13;
  localparam int TAP_BITS      = $clog2(NUM_TAPS);

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(128);

  // register select (byte address bit 2)
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // tap order of the radius-two diamond
  localparam logic [TAP_BITS-1:0] TAP_C  = TAP_BITS'(0);
  localparam logic [TAP_BITS-1:0] TAP_L  = TAP_BITS'(1);
  localparam logic [TAP_BITS-1:0] TAP_R  = TAP_BITS'(2);
  localparam logic [TAP_BITS-1:0] TAP_U  = TAP_BITS'(3);
  localparam logic [TAP_BITS-1:0] TAP_D  = TAP_BITS'(4);
  localparam logic [TAP_BITS-1:0] TAP_LL = TAP_BITS'(5);
  localparam logic [TAP_BITS-1:0] TAP_RR = TAP_BITS'(6);
  localparam logic [TAP_BITS-1:0] TAP_UU = TAP_BITS'(7);
  localparam logic [TAP_BITS-1:0] TAP_DD = TAP_BITS'(8);
  localparam logic [TAP_BITS-1:0] TAP_UL = TAP_BITS'(9);
  localparam logic [TAP_BITS-1:0] TAP_UR = TAP_BITS'(10);
  localparam logic [TAP_BITS-1:0] TAP_DL = TAP_BITS'(11);
  localparam logic [TAP_BITS-1:0] TAP_DR = TAP_BITS'(12);
  localparam logic [TAP_BITS-1:0] TAP_LAST = TAP_DR;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_EVAL
  } seq_state_e;

  // capture control, aligned with the RAM read data
  typedef struct packed {
    logic                en;
    logic [TAP_BITS-1:0] idx;
    logic                vld;
  } cap_t;

  // result control towards the output register
  typedef struct packed {
    logic strobe;
    logic coord_error;
    logic query;
  } res_t;

  function automatic logic signed [NCOORD_BITS-1:0] tap_dx(input logic [TAP_BITS-1:0] t);
    logic signed [NCOORD_BITS-1:0] d;
    unique case (t)
      TAP_L, TAP_UL, TAP_DL: d = -NCOORD_BITS'(1);
      TAP_R, TAP_UR, TAP_DR: d = NCOORD_BITS'(1);
      TAP_LL:                d = -NCOORD_BITS'(2);
      TAP_RR:                d = NCOORD_BITS'(2);
      default:               d = '0;
    endcase
    return d;
  endfunction

  function automatic logic signed [NCOORD_BITS-1:0] tap_dy(input logic [TAP_BITS-1:0] t);
    logic signed [NCOORD_BITS-1:0] d;
    unique case (t)
      TAP_U, TAP_UL, TAP_UR: d = -NCOORD_BITS'(1);
      TAP_D, TAP_DL, TAP_DR: d = NCOORD_BITS'(1);
      TAP_UU:                d = -NCOORD_BITS'(2);
      TAP_DD:                d = NCOORD_BITS'(2);
      default:               d = '0;
    endcase
    return d;
  endfunction

  // clamp a side register to the store size
  function automatic logic [SIDE_BITS-1:0] eff_side(input logic [CFG_BITS-1:0] r);
    logic [SIDE_BITS-1:0] s;
    if (int'(r) > MAX_SIDE) begin
      s = SIDE_BITS'(MAX_SIDE);
    end else begin
      s = SIDE_BITS'(r);
    end
    return s;
  endfunction

endpackage

### rtl/lbrm_ram.sv
// ----------------------------------------------------------------------------
// lbrm_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lbrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/lbrm_seq.sv
// ----------------------------------------------------------------------------
// lbrm_seq
// Command sequencer: coordinate check, label writes and the thirteen-read
// sweep over the diamond around a queried tile.
// ----------------------------------------------------------------------------
module lbrm_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [lbrm_pkg::COORD_BITS-1:0]     tile_x_i,
  input  logic [lbrm_pkg::COORD_BITS-1:0]     tile_y_i,
  input  logic [lbrm_pkg::LABEL_BITS-1:0]     zone_label_i,
  input  logic [lbrm_pkg::SIDE_BITS-1:0]      width_i,
  input  logic [lbrm_pkg::SIDE_BITS-1:0]      height_i,
  output logic                                ram_we_o,
  output logic [lbrm_pkg::ADDR_BITS-1:0]      ram_waddr_o,
  output logic [lbrm_pkg::LABEL_BITS-1:0]     ram_wdata_o,
  output logic                                ram_re_o,
  output logic [lbrm_pkg::ADDR_BITS-1:0]      ram_raddr_o,
  output lbrm_pkg::cap_t                      cap_o,
  output lbrm_pkg::res_t                      res_o
);

  lbrm_pkg::seq_state_e state_q, state_d;
  logic [lbrm_pkg::TAP_BITS-1:0]   cnt_q, cnt_d;
  logic [lbrm_pkg::COORD_BITS-1:0] x_q, y_q;
  lbrm_pkg::cap_t                  cap_q, cap_d;

  logic accept;
  logic in_grid;
  logic signed [lbrm_pkg::NCOORD_BITS-1:0] nx, ny, wlim, hlim;
  logic tap_ok;

  assign busy    = (state_q != lbrm_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign in_grid = ({1'b0, tile_x_i} < width_i) && ({1'b0, tile_y_i} < height_i);

  // tap coordinates and their grid check
  assign wlim   = signed'({1'b0, width_i});
  assign hlim   = signed'({1'b0, height_i});
  assign nx     = signed'({2'b00, x_q}) + lbrm_pkg::tap_dx(cnt_q);
  assign ny     = signed'({2'b00, y_q}) + lbrm_pkg::tap_dy(cnt_q);
  assign tap_ok = (nx >= 0) && (ny >= 0) && (nx < wlim) && (ny < hlim);

  // write straight into the store at acceptance
  assign ram_we_o    = accept && (operation_i == lbrm_pkg::OP_WRITE) && in_grid;
  assign ram_waddr_o = {tile_y_i, tile_x_i};
  assign ram_wdata_o = zone_label_i;

  assign ram_re_o    = (state_q == lbrm_pkg::ST_READ);
  assign ram_raddr_o = {ny[lbrm_pkg::COORD_BITS-1:0], nx[lbrm_pkg::COORD_BITS-1:0]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbrm_pkg::ST_IDLE: begin
        if (accept && (operation_i == lbrm_pkg::OP_QUERY) && in_grid) begin
          state_d = lbrm_pkg::ST_READ;
        end
      end
      lbrm_pkg::ST_READ: begin
        if (cnt_q == lbrm_pkg::TAP_LAST) begin
          state_d = lbrm_pkg::ST_LAST;
        end
      end
      lbrm_pkg::ST_LAST: state_d = lbrm_pkg::ST_EVAL;
      lbrm_pkg::ST_EVAL: state_d = lbrm_pkg::ST_IDLE;
      default:           state_d = lbrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = (state_q == lbrm_pkg::ST_READ) ? cnt_q + 1'b1 : '0;
    cap_d.en  = (state_q == lbrm_pkg::ST_READ);
    cap_d.idx = cnt_q;
    cap_d.vld = tap_ok;
    res_o.strobe = (accept && ((operation_i == lbrm_pkg::OP_WRITE) || !in_grid))
                   || (state_q == lbrm_pkg::ST_EVAL);
    res_o.coord_error = accept && !in_grid;
    res_o.query       = (state_q == lbrm_pkg::ST_EVAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbrm_pkg::ST_IDLE;
      cnt_q   <= '0;
      cap_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= tile_x_i;
      y_q <= tile_y_i;
    end
  end

  assign cap_o = cap_q;

`ifndef SYNTHESIS
  // no label write may land while a sweep is in flight
  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ram_we_o) else $error("label write during query sweep");

  // every capture follows a read issued in the previous cycle
  a_cap_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q.en |-> $past(state_q == lbrm_pkg::ST_READ)) else $error("capture without read");

  // evaluation is reached only after the last tap has landed
  a_eval_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbrm_pkg::ST_EVAL) |-> $past(state_q == lbrm_pkg::ST_LAST))
    else $error("evaluation out of sequence");

  // an error result never starts a sweep
  a_err_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.coord_error |=> !busy) else $error("sweep started on out-of-grid tile");
`endif

endmodule

### rtl/lbrm_eval.sv
// ----------------------------------------------------------------------------
// lbrm_eval
// Tap capture and flag decision for the diamond around a queried tile.
// ----------------------------------------------------------------------------
module lbrm_eval (
  input  logic                            clk_i,
  input  lbrm_pkg::cap_t                  cap_i,
  input  logic [lbrm_pkg::LABEL_BITS-1:0] rdata_i,
  output logic                            is_border_o,
  output logic                            is_extension_o
);

  logic [lbrm_pkg::LABEL_BITS-1:0] lab_q [lbrm_pkg::NUM_TAPS];
  logic [lbrm_pkg::NUM_TAPS-1:0]   vld_q;
  logic [lbrm_pkg::NUM_TAPS-1:0]   diff;

  always_ff @(posedge clk_i) begin
    if (cap_i.en) begin
      lab_q[cap_i.idx] <= rdata_i;
      vld_q[cap_i.idx] <= cap_i.vld;
    end
  end

  // a tap differs when it lies in the grid and its label is not the centre's
  always_comb begin
    for (int k = 0; k < lbrm_pkg::NUM_TAPS; k++) begin
      diff[k] = vld_q[k] && vld_q[lbrm_pkg::TAP_C] && (lab_q[k] != lab_q[lbrm_pkg::TAP_C]);
    end
  end

  // with no border at the centre every present neighbour shares its label,
  // so a neighbour is a border exactly when one of its outer taps differs
  assign is_border_o = diff[lbrm_pkg::TAP_L] || diff[lbrm_pkg::TAP_R] ||
                       diff[lbrm_pkg::TAP_U] || diff[lbrm_pkg::TAP_D];

  assign is_extension_o = !is_border_o && (
      (vld_q[lbrm_pkg::TAP_L] && (diff[lbrm_pkg::TAP_LL] || diff[lbrm_pkg::TAP_UL] ||
                                  diff[lbrm_pkg::TAP_DL])) ||
      (vld_q[lbrm_pkg::TAP_R] && (diff[lbrm_pkg::TAP_RR] || diff[lbrm_pkg::TAP_UR] ||
                                  diff[lbrm_pkg::TAP_DR])) ||
      (vld_q[lbrm_pkg::TAP_U] && (diff[lbrm_pkg::TAP_UU] || diff[lbrm_pkg::TAP_UL] ||
                                  diff[lbrm_pkg::TAP_UR])) ||
      (vld_q[lbrm_pkg::TAP_D] && (diff[lbrm_pkg::TAP_DD] || diff[lbrm_pkg::TAP_DL] ||
                                  diff[lbrm_pkg::TAP_DR])));

endmodule

### rtl/label_boundary_and_ring_marker.sv
// ----------------------------------------------------------------------------
// label_boundary_and_ring_marker
// Zone label grid with 4-connected border and extension ring flags.
// Results: a write or an out-of-grid command gives its result in the cycle
// after acceptance; an in-grid query gives its result after its sweep.
// Busy: a query holds busy through thirteen label reads through the single
// read port of the label memory, then a capture state and a decision state;
// writes and out-of-grid commands take one word per cycle while not busy.
// Reset: control state and the output strobe clear, both side registers
// return to 128; the label memory is not cleared and holds garbage until
// written. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module label_boundary_and_ring_marker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation_i,
  input  logic [lbrm_pkg::COORD_BITS-1:0]       tile_x_i,
  input  logic [lbrm_pkg::COORD_BITS-1:0]       tile_y_i,
  input  logic [lbrm_pkg::LABEL_BITS-1:0]       zone_label_i,
  // result channel
  output logic                                  valid_o,
  output logic                                  is_border_o,
  output logic                                  is_extension_o,
  output logic                                  coord_error_o,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lbrm_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [lbrm_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [lbrm_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  logic [lbrm_pkg::CFG_BITS-1:0]   width_q, height_q;
  logic [lbrm_pkg::SIDE_BITS-1:0]  width_eff, height_eff;
  logic                            cfg_wr;

  logic                            ram_we, ram_re;
  logic [lbrm_pkg::ADDR_BITS-1:0]  ram_waddr, ram_raddr;
  logic [lbrm_pkg::LABEL_BITS-1:0] ram_wdata, ram_rdata;
  lbrm_pkg::cap_t                  cap;
  lbrm_pkg::res_t                  res;
  logic                            eval_border, eval_ext;

  logic valid_q;
  logic border_q, ext_q, err_q;

  // --------------------------------------------------------------------------
  // Configuration registers: two side registers, written in the access phase.
  // pready stays high, so every access completes with no wait states.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lbrm_pkg::CFG_RESET;
      height_q <= lbrm_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == lbrm_pkg::REG_GRID_HEIGHT) begin
        height_q <= pwdata[lbrm_pkg::CFG_BITS-1:0];
      end else begin
        width_q <= pwdata[lbrm_pkg::CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lbrm_pkg::REG_GRID_WIDTH) begin
      prdata = lbrm_pkg::APB_DATA_BITS'(width_q);
    end else begin
      prdata = lbrm_pkg::APB_DATA_BITS'(height_q);
    end
  end

  // clamp oversize sides to the store; a zero side empties the grid
  assign width_eff  = lbrm_pkg::eff_side(width_q);
  assign height_eff = lbrm_pkg::eff_side(height_q);

  // --------------------------------------------------------------------------
  // Sequencer: checks coordinates, writes labels, sweeps the query diamond.
  // --------------------------------------------------------------------------
  lbrm_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .tile_x_i     (tile_x_i),
    .tile_y_i     (tile_y_i),
    .zone_label_i (zone_label_i),
    .width_i      (width_eff),
    .height_i     (height_eff),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .cap_o        (cap),
    .res_o        (res)
  );

  // label store, row-major with MAX_SIDE columns per row
  lbrm_ram #(
    .WIDTH (lbrm_pkg::LABEL_BITS),
    .DEPTH (lbrm_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // captures the thirteen taps and decides the two flags
  lbrm_eval u_eval (
    .clk_i          (clk_i),
    .cap_i          (cap),
    .rdata_i        (ram_rdata),
    .is_border_o    (eval_border),
    .is_extension_o (eval_ext)
  );

  // --------------------------------------------------------------------------
  // Output register: hold each result word for exactly one cycle. Flags are
  // forced low for writes and out-of-grid commands.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res.strobe;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.strobe) begin
      border_q <= res.query && eval_border;
      ext_q    <= res.query && eval_ext;
      err_q    <= res.coord_error;
    end
  end

  assign valid_o        = valid_q;
  assign is_border_o    = border_q;
  assign is_extension_o = ext_q;
  assign coord_error_o  = err_q;

endmodule

### sim/tb_label_boundary_and_ring_marker.sv
// ----------------------------------------------------------------------------
// tb_label_boundary_and_ring_marker
// Self-checking bench for the zone label grid. A short scripted table covers
// the grid corners, both commands, out-of-grid access, an empty grid and
// clamped side registers; random phases then reprogram the grid size and mix
// label writes, queries and out-of-grid noise. Every result word is checked
// against a typed expectation or a local model of the label store and its border/ring rules.
// ----------------------------------------------------------------------------
module tb_label_boundary_and_ring_marker;

  localparam int RANDOM_WORDS = 500;
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int DRAIN_SLACK  = 20;    // settle time after the last result of a drain
  localparam int WINDOW       = 6;     // side of the patch worked on per phase
  localparam int NUM_ROWS     = 27;

  typedef struct packed {
    logic border;
    logic ring;
    logic coord_err;
  } flags_t;

  // expectation plus the command that raised it, for readable reports
  typedef struct packed {
    flags_t                          flags;
    logic                            op;
    logic [lbrm_pkg::COORD_BITS-1:0] x;
    logic [lbrm_pkg::COORD_BITS-1:0] y;
  } pending_t;

  typedef enum logic {
    ROW_CMD,
    ROW_CFG
  } row_kind_e;

  // for ROW_CFG rows x[0] selects the register and data is its value
  typedef struct packed {
    row_kind_e                       kind;
    logic                            op;
    logic [lbrm_pkg::COORD_BITS-1:0] x;
    logic [lbrm_pkg::COORD_BITS-1:0] y;
    logic [lbrm_pkg::LABEL_BITS-1:0] data;
    logic                            typed;
    flags_t                          want;
  } row_t;

  localparam flags_t FLAGS_CLEAR = '{1'b0, 1'b0, 1'b0};
  localparam flags_t FLAGS_ERR   = '{1'b0, 1'b0, 1'b1};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               start;
  logic                               busy;
  logic                               operation_i;
  logic [lbrm_pkg::COORD_BITS-1:0]    tile_x_i;
  logic [lbrm_pkg::COORD_BITS-1:0]    tile_y_i;
  logic [lbrm_pkg::LABEL_BITS-1:0]    zone_label_i;
  logic                               valid_o;
  logic                               is_border_o;
  logic                               is_extension_o;
  logic                               coord_error_o;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [lbrm_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [lbrm_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [lbrm_pkg::APB_DATA_BITS-1:0] prdata;
  logic                               pready;

  label_boundary_and_ring_marker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .tile_x_i       (tile_x_i),
    .tile_y_i       (tile_y_i),
    .zone_label_i   (zone_label_i),
    .valid_o        (valid_o),
    .is_border_o    (is_border_o),
    .is_extension_o (is_extension_o),
    .coord_error_o  (coord_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // --------------------------------------------------------------------------
  // Model state: label store, which tiles hold a defined label, side registers
  // --------------------------------------------------------------------------
  logic [lbrm_pkg::LABEL_BITS-1:0] label_mem    [lbrm_pkg::STORE_DEPTH];
  bit                              tile_written [lbrm_pkg::STORE_DEPTH];
  logic [lbrm_pkg::CFG_BITS-1:0]   cfg_width;
  logic [lbrm_pkg::CFG_BITS-1:0]   cfg_height;

  pending_t pending_flags [$];
  int       error_count;
  int       stall_cycles;

  // phase shaping for the random part
  int                              win_x0, win_y0, win_w, win_h;
  logic [lbrm_pkg::LABEL_BITS-1:0] palette [2];
  bit                              no_idle;

  // Scripted opening. Typed expectations only where they are obvious: writes,
  // out-of-grid words and tiles whose whole neighbourhood holds one label.
  row_t script [NUM_ROWS] = '{
    // full 128 x 128 grid out of reset: a 0-patch in the top-left corner
    // with a single 255 tile, so (0,0) is not a border but touches one
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd0,   7'd0,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd1,   7'd0,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd2,   7'd0,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd0,   7'd1,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd0,   7'd2,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd1,   7'd1,   8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd0,   7'd0,   8'd0,   1'b0, FLAGS_CLEAR},
    // bottom-right corner, uniform 255 neighbourhood
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd127, 7'd127, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd126, 7'd127, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd127, 7'd126, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd125, 7'd127, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd127, 7'd125, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd126, 7'd126, 8'd255, 1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd127, 7'd127, 8'd0,   1'b1, FLAGS_CLEAR},
    // one-tile grid: the lone tile has no neighbours at all
    '{ROW_CFG, lbrm_pkg::OP_WRITE, 7'(lbrm_pkg::REG_GRID_WIDTH),  7'd0, 8'd1, 1'b0,
      FLAGS_CLEAR},
    '{ROW_CFG, lbrm_pkg::OP_WRITE, 7'(lbrm_pkg::REG_GRID_HEIGHT), 7'd0, 8'd1, 1'b0,
      FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd0,   7'd0,   8'd0,   1'b1, FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd1,   7'd0,   8'd170, 1'b1, FLAGS_ERR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd0,   7'd1,   8'd0,   1'b1, FLAGS_ERR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd127, 7'd127, 8'd0,   1'b1, FLAGS_ERR},
    // must leave the stored 255 alone
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd127, 7'd127, 8'd0,   1'b1, FLAGS_ERR},
    // oversize width and zero height: an empty grid
    '{ROW_CFG, lbrm_pkg::OP_WRITE, 7'(lbrm_pkg::REG_GRID_WIDTH),  7'd0, 8'd255, 1'b0,
      FLAGS_CLEAR},
    '{ROW_CFG, lbrm_pkg::OP_WRITE, 7'(lbrm_pkg::REG_GRID_HEIGHT), 7'd0, 8'd0,   1'b0,
      FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd0,   7'd0,   8'd0,   1'b1, FLAGS_ERR},
    '{ROW_CMD, lbrm_pkg::OP_WRITE, 7'd127, 7'd0,   8'd85,  1'b1, FLAGS_ERR},
    // both sides clamp back to 128: the corner is still uniform 255
    '{ROW_CFG, lbrm_pkg::OP_WRITE, 7'(lbrm_pkg::REG_GRID_HEIGHT), 7'd0, 8'd200, 1'b0,
      FLAGS_CLEAR},
    '{ROW_CMD, lbrm_pkg::OP_QUERY, 7'd127, 7'd127, 8'd0,   1'b1, FLAGS_CLEAR}
  };

  // --------------------------------------------------------------------------
  // Grid rules
  // --------------------------------------------------------------------------
  function automatic int used_side(input logic [lbrm_pkg::CFG_BITS-1:0] r);
    return (int'(r) > lbrm_pkg::MAX_SIDE) ? lbrm_pkg::MAX_SIDE : int'(r);
  endfunction

  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && y >= 0 && x < used_side(cfg_width) && y < used_side(cfg_height);
  endfunction

  function automatic int tile_index(input int x, input int y);
    return y * lbrm_pkg::MAX_SIDE + x;
  endfunction

  // an in-grid orthogonal neighbour holds another label
  function automatic bit on_boundary(input int x, input int y);
    logic [lbrm_pkg::LABEL_BITS-1:0] own;
    int nx, ny;
    own = label_mem[tile_index(x, y)];
    for (int i = 0; i < 4; i++) begin
      nx = x + ((i == 0) ? -1 : (i == 1) ? 1 : 0);
      ny = y + ((i == 2) ? -1 : (i == 3) ? 1 : 0);
      if (on_grid(nx, ny) && label_mem[tile_index(nx, ny)] != own) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the flags of one accepted word and apply any label write.
  function automatic flags_t predict_flags(input logic op, input int x, input int y,
                                           input logic [lbrm_pkg::LABEL_BITS-1:0] lab);
    flags_t f;
    int nx, ny;
    f = FLAGS_CLEAR;
    if (!on_grid(x, y)) begin
      f.coord_err = 1'b1;
    end else if (op == lbrm_pkg::OP_WRITE) begin
      label_mem[tile_index(x, y)]    = lab;
      tile_written[tile_index(x, y)] = 1'b1;
    end else if (on_boundary(x, y)) begin
      f.border = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) begin
        nx = x + ((i == 0) ? -1 : (i == 1) ? 1 : 0);
        ny = y + ((i == 2) ? -1 : (i == 3) ? 1 : 0);
        if (on_grid(nx, ny) && on_boundary(nx, ny)) f.ring = 1'b1;
      end
    end
    return f;
  endfunction

  // Find an in-grid tile of the radius-two diamond that was never written;
  // a query there would read an undefined label.
  function automatic bit diamond_gap(input int x, input int y, output int gx, output int gy);
    gx = x;
    gy = y;
    for (int dy = -2; dy <= 2; dy++) begin
      for (int dx = -2; dx <= 2; dx++) begin
        if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) <= 2 && on_grid(x + dx, y + dy) &&
            !tile_written[tile_index(x + dx, y + dy)]) begin
          gx = x + dx;
          gy = y + dy;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("mismatch @%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Clock, stall watchdog and result checker
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Count cycles in which no word, result or register access moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The strobe cannot be held off: take each result at the edge that ends it.
  always @(posedge clk_i) begin : result_check
    pending_t due;
    flags_t   got;
    if (rst_ni && valid_o) begin
      got = '{is_border_o, is_extension_o, coord_error_o};
      if (pending_flags.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing pending", got));
      end else begin
        due = pending_flags.pop_front();
        if (got.border !== due.flags.border)
          report_mismatch($sformatf("is_border op=%b (%0d,%0d) got %b want %b",
                                    due.op, due.x, due.y, got.border, due.flags.border));
        if (got.ring !== due.flags.ring)
          report_mismatch($sformatf("is_extension op=%b (%0d,%0d) got %b want %b",
                                    due.op, due.x, due.y, got.ring, due.flags.ring));
        if (got.coord_err !== due.flags.coord_err)
          report_mismatch($sformatf("coord_error op=%b (%0d,%0d) got %b want %b",
                                    due.op, due.x, due.y, got.coord_err,
                                    due.flags.coord_err));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers: everything changes at the falling edge
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word, hold it until taken, then log what it should give.
  task automatic send_word(input logic op, input logic [lbrm_pkg::COORD_BITS-1:0] x,
                           input logic [lbrm_pkg::COORD_BITS-1:0] y,
                           input logic [lbrm_pkg::LABEL_BITS-1:0] lab,
                           input int gap, input bit typed, input flags_t want);
    flags_t   f;
    pending_t due;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start        = 1'b1;
    operation_i  = op;
    tile_x_i     = x;
    tile_y_i     = y;
    zone_label_i = lab;
    do @(posedge clk_i); while (busy);
    f = predict_flags(op, int'(x), int'(y), lab);
    due.flags = typed ? want : f;
    due.op    = op;
    due.x     = x;
    due.y     = y;
    pending_flags.push_back(due);
  endtask

  // Drop start and hold until every result is in, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_flags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic check_register(input logic sel,
                                input logic [lbrm_pkg::CFG_BITS-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {sel, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[lbrm_pkg::CFG_BITS-1:0] !== want)
      report_mismatch($sformatf("register %b reads %0d want %0d", sel,
                                prdata[lbrm_pkg::CFG_BITS-1:0], want));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write a side register (block idle) and read it back.
  task automatic set_register(input logic sel, input logic [lbrm_pkg::CFG_BITS-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = lbrm_pkg::APB_DATA_BITS'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == lbrm_pkg::REG_GRID_WIDTH) begin
      cfg_width = value;
    end else begin
      cfg_height = value;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_register(sel, value);
  endtask

  // --------------------------------------------------------------------------
  // Random phases
  // --------------------------------------------------------------------------
  function automatic logic [lbrm_pkg::LABEL_BITS-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return palette[0];
    if (r < 95) return palette[1];
    return lbrm_pkg::LABEL_BITS'($urandom);
  endfunction

  // Drain, pick a grid size (mostly narrow, sometimes clamped, full or empty)
  // and a patch of it to work on, so that queries find defined labels.
  task automatic begin_phase();
    logic [lbrm_pkg::CFG_BITS-1:0] w, h;
    int ew, eh;
    drain();
    w = lbrm_pkg::CFG_BITS'($urandom_range(1, 8));
    h = lbrm_pkg::CFG_BITS'($urandom_range(1, 8));
    case ($urandom_range(0, 11))
      0: w = lbrm_pkg::CFG_BITS'($urandom_range(128, 255));
      1: h = lbrm_pkg::CFG_BITS'($urandom_range(128, 255));
      2: begin
        w = lbrm_pkg::CFG_BITS'(lbrm_pkg::MAX_SIDE);
        h = lbrm_pkg::CFG_BITS'($urandom_range(128, 255));
      end
      3: begin
        if ($urandom_range(0, 1) == 1) w = '0;
        else h = '0;
      end
      4: w = lbrm_pkg::CFG_BITS'(1);
      default: ;
    endcase
    set_register(lbrm_pkg::REG_GRID_WIDTH, w);
    set_register(lbrm_pkg::REG_GRID_HEIGHT, h);
    ew    = used_side(cfg_width);
    eh    = used_side(cfg_height);
    win_w = (ew < WINDOW) ? ew : WINDOW;
    win_h = (eh < WINDOW) ? eh : WINDOW;
    case ($urandom_range(0, 2))
      0: win_x0 = 0;
      1: win_x0 = ew - win_w;
      default: win_x0 = $urandom_range(0, ew - win_w);
    endcase
    case ($urandom_range(0, 2))
      0: win_y0 = 0;
      1: win_y0 = eh - win_h;
      default: win_y0 = $urandom_range(0, eh - win_h);
    endcase
    palette[0] = lbrm_pkg::LABEL_BITS'($urandom);
    palette[1] = lbrm_pkg::LABEL_BITS'($urandom);
    no_idle    = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly writes and queries inside the patch; a query whose neighbourhood
  // still has undefined labels turns into a write that fills one of them.
  // The rest is noise outside the grid.
  task automatic pick_word(output logic op, output logic [lbrm_pkg::COORD_BITS-1:0] x,
                           output logic [lbrm_pkg::COORD_BITS-1:0] y,
                           output logic [lbrm_pkg::LABEL_BITS-1:0] lab);
    int ew, eh, r, gx, gy;
    ew  = used_side(cfg_width);
    eh  = used_side(cfg_height);
    r   = $urandom_range(0, 99);
    lab = pick_label();
    if (ew == 0 || eh == 0 ||
        (r < 12 && (ew < lbrm_pkg::MAX_SIDE || eh < lbrm_pkg::MAX_SIDE))) begin
      op  = 1'($urandom);
      lab = lbrm_pkg::LABEL_BITS'($urandom);
      if (ew < lbrm_pkg::MAX_SIDE &&
          (eh == lbrm_pkg::MAX_SIDE || $urandom_range(0, 1) == 1)) begin
        x = lbrm_pkg::COORD_BITS'($urandom_range(ew, lbrm_pkg::MAX_SIDE - 1));
        y = lbrm_pkg::COORD_BITS'($urandom_range(0, lbrm_pkg::MAX_SIDE - 1));
      end else begin
        x = lbrm_pkg::COORD_BITS'($urandom_range(0, lbrm_pkg::MAX_SIDE - 1));
        y = lbrm_pkg::COORD_BITS'($urandom_range(eh, lbrm_pkg::MAX_SIDE - 1));
      end
    end else begin
      x  = lbrm_pkg::COORD_BITS'(win_x0 + $urandom_range(0, win_w - 1));
      y  = lbrm_pkg::COORD_BITS'(win_y0 + $urandom_range(0, win_h - 1));
      op = (r < 45) ? lbrm_pkg::OP_WRITE : lbrm_pkg::OP_QUERY;
      if (op == lbrm_pkg::OP_QUERY && diamond_gap(int'(x), int'(y), gx, gy)) begin
        op = lbrm_pkg::OP_WRITE;
        x  = lbrm_pkg::COORD_BITS'(gx);
        y  = lbrm_pkg::COORD_BITS'(gy);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic                            op;
    logic [lbrm_pkg::COORD_BITS-1:0] x, y;
    logic [lbrm_pkg::LABEL_BITS-1:0] lab;
    int                              words_sent;
    int                              phase_len;

    // every input known from time zero, with reset held low at the start
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = lbrm_pkg::OP_WRITE;
    tile_x_i     = '0;
    tile_y_i     = '0;
    zone_label_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    error_count  = 0;
    no_idle      = 1'b0;
    cfg_width    = lbrm_pkg::CFG_RESET;
    cfg_height   = lbrm_pkg::CFG_RESET;
    palette[0]   = '0;
    palette[1]   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // both side registers come out of reset at 128
    check_register(lbrm_pkg::REG_GRID_WIDTH, lbrm_pkg::CFG_RESET);
    check_register(lbrm_pkg::REG_GRID_HEIGHT, lbrm_pkg::CFG_RESET);

    // walk the scripted table; register rows wait for an idle block
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        set_register(script[i].x[0], script[i].data);
      end else begin
        send_word(script[i].op, script[i].x, script[i].y, script[i].data, pick_gap(),
                  script[i].typed, script[i].want);
      end
    end

    // random phases, each opened by a full drain and a new grid size
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      begin_phase();
      phase_len = $urandom_range(25, 60);
      for (int k = 0; k < phase_len; k++) begin
        pick_word(op, x, y, lab);
        send_word(op, x, y, lab, pick_gap(), 1'b0, FLAGS_CLEAR);
        words_sent++;
      end
    end

    drain();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
